/* sv/prp_pkg.sv */
// Shared types, constants and the clamp helper of the pinhole radial projection block.
// Used by prp_norm and pinhole_radial_projection; depends on nothing else.
`default_nettype none

package prp_pkg;

    // Fixed widths of the datapath.
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned FOCAL_W   = 31;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Fixed-point constants.
    localparam logic signed [DATA_W-1:0] Q24_ONE = 32'sh0100_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_DEPTH = 2'd1,
        STATUS_SAT       = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_RADIAL_K1 = 3'd4,
        REG_RADIAL_K2 = 3'd5
    } reg_index_t;

    // A value clamped to 32 signed bits, with a flag set when the clamp took effect.
    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } prp_clamp_t;

    // Normalized point as it leaves the divider pipeline.
    typedef struct packed {
        logic                     valid;
        logic                     bad;
        logic                     sat;
        logic signed [DATA_W-1:0] xp;
        logic signed [DATA_W-1:0] yp;
    } prp_norm_t;

    // Saturate a wide signed value to 32 signed bits.
    function automatic prp_clamp_t clamp32(input logic signed [65:0] v);
        prp_clamp_t r;
        if (v > 66'sd2147483647) begin
            r.sat   = 1'b1;
            r.value = SAT_MAX;
        end else if (v < -66'sd2147483648) begin
            r.sat   = 1'b1;
            r.value = SAT_MIN;
        end else begin
            r.sat   = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/prp_norm.sv */
// Pipelined divider that normalizes x and y by the depth z, one bit of quotient a stage.
// Depends on prp_pkg for widths, the clamp result type and the output struct.
`default_nettype none

module prp_norm
    import prp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic signed [DATA_W-1:0] in_x,
    input  wire logic signed [DATA_W-1:0] in_y,
    input  wire logic signed [DATA_W-1:0] in_z,
    output prp_norm_t                     norm_out
);

    // Stage 0 is the entry register; stage k holds the state after k quotient bits.
    logic                 valid_reg [DIV_STEPS+1];
    logic                 bad_reg   [DIV_STEPS+1];
    logic                 xneg_reg  [DIV_STEPS+1];
    logic                 yneg_reg  [DIV_STEPS+1];
    logic                 xovf_reg  [DIV_STEPS+1];
    logic                 yovf_reg  [DIV_STEPS+1];
    logic [FOCAL_W-1:0]   z_reg     [DIV_STEPS+1];
    logic [FOCAL_W-1:0]   xrem_reg  [DIV_STEPS+1];
    logic [FOCAL_W-1:0]   yrem_reg  [DIV_STEPS+1];
    logic [DATA_W-1:0]    xdq_reg   [DIV_STEPS+1];
    logic [DATA_W-1:0]    ydq_reg   [DIV_STEPS+1];

    logic                 bad_next  [DIV_STEPS+1];
    logic                 xneg_next [DIV_STEPS+1];
    logic                 yneg_next [DIV_STEPS+1];
    logic                 xovf_next [DIV_STEPS+1];
    logic                 yovf_next [DIV_STEPS+1];
    logic [FOCAL_W-1:0]   z_next    [DIV_STEPS+1];
    logic [FOCAL_W-1:0]   xrem_next [DIV_STEPS+1];
    logic [FOCAL_W-1:0]   yrem_next [DIV_STEPS+1];
    logic [DATA_W-1:0]    xdq_next  [DIV_STEPS+1];
    logic [DATA_W-1:0]    ydq_next  [DIV_STEPS+1];

    logic [DATA_W-1:0]    abs_x;
    logic [DATA_W-1:0]    abs_y;
    prp_norm_t            norm_reg;
    prp_norm_t            norm_next;

    // One restoring step: bring in the next dividend bit and subtract when it fits.
    function automatic logic [FOCAL_W+DATA_W-1:0] div_step(
        input logic [FOCAL_W-1:0] rem,
        input logic [DATA_W-1:0]  dq,
        input logic [FOCAL_W-1:0] divisor
    );
        logic [DATA_W-1:0]  t;
        logic [DATA_W-1:0]  diff;
        logic               ge;
        logic [FOCAL_W-1:0] rem_out;
        t    = {rem, dq[DATA_W-1]};
        diff = t - {1'b0, divisor};
        ge   = (t >= {1'b0, divisor});
        rem_out = ge ? diff[FOCAL_W-1:0] : t[FOCAL_W-1:0];
        return {rem_out, dq[DATA_W-2:0], ge};
    endfunction

    // Turn a quotient magnitude into a signed Q16.16 value with saturation.
    function automatic prp_clamp_t finish(
        input logic              neg,
        input logic              ovf,
        input logic [DATA_W-1:0] q
    );
        prp_clamp_t r;
        if (!neg) begin
            r.sat   = ovf | q[DATA_W-1];
            r.value = r.sat ? SAT_MAX : $signed(q);
        end else begin
            r.sat   = ovf | (q[DATA_W-1] & (|q[DATA_W-2:0]));
            r.value = r.sat ? SAT_MIN : $signed(-q);
        end
        return r;
    endfunction

    // Entry: magnitudes, depth check, and the upper dividend bits as the first remainder.
    // A quotient of 2^32 or more shows up here as upper bits not below the divisor.
    // The division steps follow, each working on the register of the stage before.
    always_comb begin
        abs_x = in_x[DATA_W-1] ? (~in_x + 1'b1) : in_x;
        abs_y = in_y[DATA_W-1] ? (~in_y + 1'b1) : in_y;
        bad_next[0]  = in_z[DATA_W-1] | (in_z == '0);
        xneg_next[0] = in_x[DATA_W-1];
        yneg_next[0] = in_y[DATA_W-1];
        z_next[0]    = in_z[FOCAL_W-1:0];
        xovf_next[0] = ({15'd0, abs_x[DATA_W-1:16]} >= in_z[FOCAL_W-1:0]);
        yovf_next[0] = ({15'd0, abs_y[DATA_W-1:16]} >= in_z[FOCAL_W-1:0]);
        xrem_next[0] = {15'd0, abs_x[DATA_W-1:16]};
        yrem_next[0] = {15'd0, abs_y[DATA_W-1:16]};
        xdq_next[0]  = {abs_x[15:0], 16'd0};
        ydq_next[0]  = {abs_y[15:0], 16'd0};
        for (int k = 1; k <= DIV_STEPS; k++) begin
            bad_next[k]  = bad_reg[k-1];
            xneg_next[k] = xneg_reg[k-1];
            yneg_next[k] = yneg_reg[k-1];
            xovf_next[k] = xovf_reg[k-1];
            yovf_next[k] = yovf_reg[k-1];
            z_next[k]    = z_reg[k-1];
            {xrem_next[k], xdq_next[k]} = div_step(xrem_reg[k-1], xdq_reg[k-1], z_reg[k-1]);
            {yrem_next[k], ydq_next[k]} = div_step(yrem_reg[k-1], ydq_reg[k-1], z_reg[k-1]);
        end
    end

    // Final stage: apply the signs and clamp to 32 bits.
    always_comb begin
        prp_clamp_t cx;
        prp_clamp_t cy;
        cx = finish(xneg_reg[DIV_STEPS], xovf_reg[DIV_STEPS], xdq_reg[DIV_STEPS]);
        cy = finish(yneg_reg[DIV_STEPS], yovf_reg[DIV_STEPS], ydq_reg[DIV_STEPS]);
        norm_next.valid = valid_reg[DIV_STEPS];
        norm_next.bad   = bad_reg[DIV_STEPS];
        norm_next.sat   = cx.sat | cy.sat;
        norm_next.xp    = cx.value;
        norm_next.yp    = cy.value;
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Payload of the stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                bad_reg[k]  <= bad_next[k];
                xneg_reg[k] <= xneg_next[k];
                yneg_reg[k] <= yneg_next[k];
                xovf_reg[k] <= xovf_next[k];
                yovf_reg[k] <= yovf_next[k];
                z_reg[k]    <= z_next[k];
                xrem_reg[k] <= xrem_next[k];
                yrem_reg[k] <= yrem_next[k];
                xdq_reg[k]  <= xdq_next[k];
                ydq_reg[k]  <= ydq_next[k];
            end
        end
    end

    // Output register; only its valid bit is cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_reg.valid <= 1'b0;
        end else if (en) begin
            norm_reg <= norm_next;
        end
    end

    assign norm_out = norm_reg;

endmodule

`default_nettype wire

/* sv/pinhole_radial_projection.sv */
// Top level of the pinhole projection with two-term radial distortion.
// Depends on prp_pkg and instantiates the normalizing divider prp_norm.
//
// Usage:
//   Each word on the s_ channel is one camera-frame point (Q16.16); each word on
//   the m_ channel is the projected pixel (Q16.16) with a status code. Both use
//   valid/ready. The cfg_ channel writes one register per word (index, data);
//   cfg_ready is always high, and writes are meant for times the block is idle.
//   Throughput is one point per cycle while the skid register is empty. A result
//   reaches m_valid through the divider's entry register and 32 quotient stages,
//   one sign and clamp stage, nine stages for r2, the distortion polynomial and
//   the focal scaling, then the output register.
//   When the receiver stalls, the pipeline keeps moving until one word lands in
//   the skid register behind the output register; then the whole pipeline and
//   s_ready hold until the output drains. Nothing is lost or repeated.
//   A depth of zero or less returns zero pixels with status 1; any clamp of an
//   intermediate returns status 2. Reset empties the pipeline and loads focal
//   lengths of 1.0, a zero principal point and zero distortion.
`default_nettype none

module pinhole_radial_projection
    import prp_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Configuration write channel.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [DATA_W-1:0]           cfg_data,
    // Input points.
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [DATA_W-1:0]    s_point_x,
    input  wire logic signed [DATA_W-1:0]    s_point_y,
    input  wire logic signed [DATA_W-1:0]    s_point_z,
    // Output pixels.
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [DATA_W-1:0]         m_pixel_u,
    output logic signed [DATA_W-1:0]         m_pixel_v,
    output logic [1:0]                       m_status
);

    // Configuration registers.
    logic [FOCAL_W-1:0]       focal_x_reg;
    logic [FOCAL_W-1:0]       focal_y_reg;
    logic signed [DATA_W-1:0] center_x_reg;
    logic signed [DATA_W-1:0] center_y_reg;
    logic signed [DATA_W-1:0] radial_k1_reg;
    logic signed [DATA_W-1:0] radial_k2_reg;

    logic      en;
    prp_norm_t norm;

    // Stage A: squares.
    logic                     a_valid_reg, a_bad_reg, a_sat_reg;
    logic signed [DATA_W-1:0] a_xp_reg, a_yp_reg;
    logic signed [63:0]       a_xx_reg, a_yy_reg;
    logic signed [63:0]       a_xx_next, a_yy_next;
    // Stage B: r2.
    logic                     b_valid_reg, b_bad_reg, b_sat_reg;
    logic signed [DATA_W-1:0] b_xp_reg, b_yp_reg;
    logic [DATA_W-1:0]        b_r2_reg;
    logic [63:0]              b_sum;
    logic                     b_ovf;
    logic [DATA_W-1:0]        b_r2_next;
    // Stage C: k2 * r2.
    logic                     c_valid_reg, c_bad_reg, c_sat_reg;
    logic signed [DATA_W-1:0] c_xp_reg, c_yp_reg;
    logic [DATA_W-1:0]        c_r2_reg;
    logic signed [64:0]       c_m1_reg, c_m1_next;
    // Stage D: s.
    logic                     d_valid_reg, d_bad_reg, d_sat_reg;
    logic signed [DATA_W-1:0] d_xp_reg, d_yp_reg;
    logic [DATA_W-1:0]        d_r2_reg;
    logic signed [DATA_W-1:0] d_s_reg;
    prp_clamp_t               d_s_next;
    // Stage E: s * r2.
    logic                     e_valid_reg, e_bad_reg, e_sat_reg;
    logic signed [DATA_W-1:0] e_xp_reg, e_yp_reg;
    logic signed [64:0]       e_m2_reg, e_m2_next;
    // Stage F: distortion factor.
    logic                     f_valid_reg, f_bad_reg, f_sat_reg;
    logic signed [DATA_W-1:0] f_xp_reg, f_yp_reg;
    logic signed [DATA_W-1:0] f_d_reg;
    prp_clamp_t               f_d_next;
    // Stage G: factor times normalized coordinates.
    logic                     g_valid_reg, g_bad_reg, g_sat_reg;
    logic signed [63:0]       g_px_reg, g_py_reg, g_px_next, g_py_next;
    // Stage H: distorted coordinates.
    logic                     h_valid_reg, h_bad_reg, h_sat_reg;
    logic signed [DATA_W-1:0] h_ax_reg, h_ay_reg;
    prp_clamp_t               h_ax_next, h_ay_next;
    // Stage I: focal scaling.
    logic                     i_valid_reg, i_bad_reg, i_sat_reg;
    logic signed [63:0]       i_pu_reg, i_pv_reg, i_pu_next, i_pv_next;
    // Final values entering the output register.
    prp_clamp_t               j_u, j_v;
    logic signed [DATA_W-1:0] j_pixel_u, j_pixel_v;
    status_t                  j_status;
    // Output and skid registers.
    logic                     m_valid_reg, skid_valid_reg;
    logic signed [DATA_W-1:0] m_u_reg, m_v_reg, skid_u_reg, skid_v_reg;
    status_t                  m_status_reg, skid_status_reg;

    // The pipeline moves unless a word is parked in the skid register.
    assign en        = !skid_valid_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg   <= 31'd65536;
            focal_y_reg   <= 31'd65536;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radial_k1_reg <= '0;
            radial_k2_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FOCAL_X:   focal_x_reg   <= cfg_data[FOCAL_W-1:0];
                REG_FOCAL_Y:   focal_y_reg   <= cfg_data[FOCAL_W-1:0];
                REG_CENTER_X:  center_x_reg  <= cfg_data;
                REG_CENTER_Y:  center_y_reg  <= cfg_data;
                REG_RADIAL_K1: radial_k1_reg <= cfg_data;
                REG_RADIAL_K2: radial_k2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Normalize x and y by the depth.
    prp_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_x     (s_point_x),
        .in_y     (s_point_y),
        .in_z     (s_point_z),
        .norm_out (norm)
    );

    // Datapath between the stages.
    always_comb begin
        a_xx_next = 64'(norm.xp) * 64'(norm.xp);
        a_yy_next = 64'(norm.yp) * 64'(norm.yp);

        // r2 in Q8.24 is the sum of squares shifted down by 8, clamped to 32 bits.
        b_sum     = $unsigned(a_xx_reg) + $unsigned(a_yy_reg);
        b_ovf     = |b_sum[63:40];
        b_r2_next = b_ovf ? '1 : b_sum[39:8];

        c_m1_next = 65'(radial_k2_reg) * 65'($signed({1'b0, b_r2_reg}));

        d_s_next  = clamp32($signed({{34{radial_k1_reg[DATA_W-1]}}, radial_k1_reg})
                            + $signed({c_m1_reg[64], (c_m1_reg >>> 24)}));

        e_m2_next = 65'(d_s_reg) * 65'($signed({1'b0, d_r2_reg}));

        f_d_next  = clamp32($signed({{34{Q24_ONE[DATA_W-1]}}, Q24_ONE})
                            + $signed({e_m2_reg[64], (e_m2_reg >>> 24)}));

        g_px_next = 64'(f_d_reg) * 64'(f_xp_reg);
        g_py_next = 64'(f_d_reg) * 64'(f_yp_reg);

        h_ax_next = clamp32($signed({{2{g_px_reg[63]}}, (g_px_reg >>> 24)}));
        h_ay_next = clamp32($signed({{2{g_py_reg[63]}}, (g_py_reg >>> 24)}));

        i_pu_next = 64'($signed({1'b0, focal_x_reg})) * 64'(h_ax_reg);
        i_pv_next = 64'($signed({1'b0, focal_y_reg})) * 64'(h_ay_reg);

        // Add the principal point and form the final word.
        j_u = clamp32($signed({{34{center_x_reg[DATA_W-1]}}, center_x_reg})
                      + $signed({{2{i_pu_reg[63]}}, (i_pu_reg >>> 16)}));
        j_v = clamp32($signed({{34{center_y_reg[DATA_W-1]}}, center_y_reg})
                      + $signed({{2{i_pv_reg[63]}}, (i_pv_reg >>> 16)}));
        if (i_bad_reg) begin
            j_pixel_u = '0;
            j_pixel_v = '0;
            j_status  = STATUS_BAD_DEPTH;
        end else begin
            j_pixel_u = j_u.value;
            j_pixel_v = j_v.value;
            j_status  = (i_sat_reg | j_u.sat | j_v.sat) ? STATUS_SAT : STATUS_OK;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= norm.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
        end
    end

    // Payload of the stages; depth and saturation flags travel with the data.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_bad_reg <= norm.bad;
            a_sat_reg <= norm.sat;
            a_xp_reg  <= norm.xp;
            a_yp_reg  <= norm.yp;
            a_xx_reg  <= a_xx_next;
            a_yy_reg  <= a_yy_next;

            b_bad_reg <= a_bad_reg;
            b_sat_reg <= a_sat_reg | b_ovf;
            b_xp_reg  <= a_xp_reg;
            b_yp_reg  <= a_yp_reg;
            b_r2_reg  <= b_r2_next;

            c_bad_reg <= b_bad_reg;
            c_sat_reg <= b_sat_reg;
            c_xp_reg  <= b_xp_reg;
            c_yp_reg  <= b_yp_reg;
            c_r2_reg  <= b_r2_reg;
            c_m1_reg  <= c_m1_next;

            d_bad_reg <= c_bad_reg;
            d_sat_reg <= c_sat_reg | d_s_next.sat;
            d_xp_reg  <= c_xp_reg;
            d_yp_reg  <= c_yp_reg;
            d_r2_reg  <= c_r2_reg;
            d_s_reg   <= d_s_next.value;

            e_bad_reg <= d_bad_reg;
            e_sat_reg <= d_sat_reg;
            e_xp_reg  <= d_xp_reg;
            e_yp_reg  <= d_yp_reg;
            e_m2_reg  <= e_m2_next;

            f_bad_reg <= e_bad_reg;
            f_sat_reg <= e_sat_reg | f_d_next.sat;
            f_xp_reg  <= e_xp_reg;
            f_yp_reg  <= e_yp_reg;
            f_d_reg   <= f_d_next.value;

            g_bad_reg <= f_bad_reg;
            g_sat_reg <= f_sat_reg;
            g_px_reg  <= g_px_next;
            g_py_reg  <= g_py_next;

            h_bad_reg <= g_bad_reg;
            h_sat_reg <= g_sat_reg | h_ax_next.sat | h_ay_next.sat;
            h_ax_reg  <= h_ax_next.value;
            h_ay_reg  <= h_ay_next.value;

            i_bad_reg <= h_bad_reg;
            i_sat_reg <= h_sat_reg;
            i_pu_reg  <= i_pu_next;
            i_pv_reg  <= i_pv_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= i_valid_reg;
            end
        end else if (en && i_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload.
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_u_reg      <= skid_u_reg;
                m_v_reg      <= skid_v_reg;
                m_status_reg <= skid_status_reg;
            end else begin
                m_u_reg      <= j_pixel_u;
                m_v_reg      <= j_pixel_v;
                m_status_reg <= j_status;
            end
        end else if (en && i_valid_reg) begin
            skid_u_reg      <= j_pixel_u;
            skid_v_reg      <= j_pixel_v;
            skid_status_reg <= j_status;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pixel_u = m_u_reg;
    assign m_pixel_v = m_v_reg;
    assign m_status  = m_status_reg;

endmodule

`default_nettype wire
